/* rtl/core/rdfd_pkg.sv */
// rdfd_pkg: shared types and constants of the run-length delta frame decoder
`default_nettype none

package rdfd_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES = 1024;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  // header byte layout
  localparam int unsigned    MODE_BIT   = 7;
  localparam logic [6:0]     COUNT_MASK = 7'b1111111;

  // pixel counts carried by a result
  localparam logic [1:0] PIX_ONE = 2'd1;
  localparam logic [1:0] PIX_TWO = 2'd2;

  // input item actions
  localparam logic ACT_STREAM = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;

  // stream parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_VALUE   = 2'd2
  } phase_e;

  // controller sequence state
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EMIT = 2'd2
  } ctrl_state_e;

  // input request payload
  typedef struct packed {
    logic       action;
    logic       frame_start;
    logic [7:0] data_byte;
    logic [9:0] base_addr;
  } rdfd_in_t;

  // result payload
  typedef struct packed {
    logic [9:0] pixel_addr;
    logic [7:0] pixel_first;
    logic [7:0] pixel_second;
    logic [1:0] pixel_count;
    logic       run_last;
  } rdfd_out_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic read;
    logic emit;
  } rdfd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_run;
    logic more_left;
    logic out_free;
  } rdfd_status_t;

endpackage

`default_nettype wire

/* rtl/core/rdfd_if.sv */
// rdfd_in_if and rdfd_out_if: valid/ready channels of the decoder
`default_nettype none

interface rdfd_in_if;
  logic               valid;
  logic               ready;
  rdfd_pkg::rdfd_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rdfd_out_if;
  logic                valid;
  logic                ready;
  rdfd_pkg::rdfd_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/rdfd_ctrl.sv */
// rdfd_ctrl: sequencing state machine of the decoder
`default_nettype none

module rdfd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rdfd_pkg::rdfd_status_t status_i,
  output rdfd_pkg::rdfd_cmd_t    cmd_o
);
  import rdfd_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.start_run) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) state_d = status_i.more_left ? ST_READ : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/rdfd_datapath.sv */
// rdfd_datapath: parser state, base frame memory, pixel math and result register
`default_nettype none

module rdfd_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rdfd_pkg::rdfd_in_t     in_data_i,
  input  rdfd_pkg::rdfd_cmd_t    cmd_i,
  output rdfd_pkg::rdfd_status_t status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rdfd_pkg::rdfd_out_t    out_data_o
);
  import rdfd_pkg::*;

  // base frame store
  logic [7:0] base_mem [FRAME_BYTES];

  // parser and run state
  phase_e           phase_q, phase_d;
  logic [6:0]       run_q, run_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [6:0]       left_q, left_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  logic [7:0] value_q;
  logic [7:0] rd_a_q, rd_b_q;
  rdfd_out_t  out_q, out_d;

  // effective state for the item on the input, after a frame start
  phase_e           eff_phase;
  logic [6:0]       eff_run;
  logic [POS_W-1:0] eff_pos;
  logic [6:0]       hdr_cnt;
  logic [6:0]       run_dec;
  logic [POS_W-1:0] pos_p1, pos_p2;
  logic             pair;

  assign eff_phase = in_data_i.frame_start ? PH_HEADER : phase_q;
  assign eff_run   = in_data_i.frame_start ? '0 : run_q;
  assign eff_pos   = in_data_i.frame_start ? '0 : pos_q;
  assign hdr_cnt   = in_data_i.data_byte[6:0] & COUNT_MASK;
  assign run_dec   = eff_run - 7'd1;

  // wrapping position increments
  assign pos_p1 = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
  assign pos_p2 = (pos_p1 == POS_LAST) ? '0 : pos_p1 + POS_W'(1);
  assign pair   = (left_q >= 7'd2);

  // status toward the controller
  assign status_o.start_run = (in_data_i.action == ACT_STREAM) &&
                              ((eff_phase == PH_LITERAL) ||
                               ((eff_phase == PH_VALUE) && (eff_run != '0)));
  assign status_o.more_left = (left_q > 7'd2);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // parser and position update
  always_comb begin
    phase_d     = phase_q;
    run_d       = run_q;
    pos_d       = pos_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_i.take && (in_data_i.action == ACT_STREAM)) begin
      pos_d = eff_pos;
      case (eff_phase)
        PH_LITERAL: begin
          left_d  = 7'd1;
          run_d   = run_dec;
          phase_d = (run_dec == '0) ? PH_HEADER : PH_LITERAL;
        end
        PH_VALUE: begin
          left_d  = eff_run;
          run_d   = '0;
          phase_d = PH_HEADER;
        end
        default: begin
          left_d = '0;
          run_d  = hdr_cnt;
          if (in_data_i.data_byte[MODE_BIT]) begin
            phase_d = (hdr_cnt != '0) ? PH_LITERAL : PH_HEADER;
          end else begin
            phase_d = PH_VALUE;
          end
        end
      endcase
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      if (pair) begin
        left_d = left_q - 7'd2;
        pos_d  = pos_p2;
      end else begin
        left_d = '0;
        pos_d  = pos_p1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      run_q       <= '0;
      pos_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      run_q       <= run_d;
      pos_q       <= pos_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // base frame write on a load request, pair read at the current position
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (in_data_i.action == ACT_LOAD)) begin
      base_mem[in_data_i.base_addr[POS_W-1:0]] <= in_data_i.data_byte;
    end
    if (cmd_i.read) begin
      rd_a_q <= base_mem[pos_q];
      rd_b_q <= base_mem[pos_p1];
    end
  end

  // result assembly
  always_comb begin
    out_d              = out_q;
    out_d.pixel_addr   = 10'(pos_q);
    out_d.pixel_first  = rd_a_q - value_q;
    out_d.pixel_second = pair ? (rd_b_q - value_q) : 8'd0;
    out_d.pixel_count  = pair ? PIX_TWO : PIX_ONE;
    out_d.run_last     = (left_q <= 7'd2);
  end

  // value byte capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) value_q <= in_data_i.data_byte;
    if (cmd_i.emit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* rtl/core/rle_delta_frame_decoder.sv */
// rle_delta_frame_decoder: top level joining controller and datapath
//
//   channel | dir | modport | payload
//   in_i    | in  | sink    | action, frame_start, data_byte, base_addr
//   out_o   | out | source  | pixel_addr, pixel_first, pixel_second, pixel_count, run_last
//
// Load, header and empty value requests give no result.
// A literal byte or a value byte with a run of n pixels is taken, then for each
// result of up to two pixels the base frame pair is read (two read ports) and the
// result is written to the output register once that register is free.
// Reset clears position, parser and run counts; the base frame is not cleared.
// in_i.ready is low while a run is being emitted; a stalled result holds in the
// output register and the next request is taken while it waits.
`default_nettype none

module rle_delta_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  rdfd_in_if.sink     in_i,
  rdfd_out_if.source  out_o
);
  import rdfd_pkg::*;

  rdfd_cmd_t    cmd;
  rdfd_status_t status;
  logic         in_ready;
  logic         out_valid;
  rdfd_out_t    out_data;

  // sequencing
  rdfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // decode datapath
  rdfd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  // channel hookup
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

`default_nettype wire

/* tb/tb_rle_delta_frame_decoder.sv */
// tb_rle_delta_frame_decoder: self-checking bench with a pixel predictor and random handshakes
module tb_rle_delta_frame_decoder;
  import rdfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned PRELOAD_BYTES = 136;
  localparam int unsigned RANDOM_ITEMS  = 100;
  localparam int unsigned RESTART_FROM  = 50;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned REPORT_MAX    = 10;
  localparam rdfd_out_t   NO_PIXELS     = '0;

  // one directed request, with its result typed in where it is obvious
  typedef struct packed {
    rdfd_in_t  req;
    logic      typed;
    rdfd_out_t want;
  } stim_row_t;

  // base frame holds base[i] = i[7:0] for i below PRELOAD_BYTES when this table starts
  localparam int unsigned DIRECTED_ROWS = 24;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // loads at the address extremes, frame start ignored on a load
    '{'{ACT_LOAD,   1'b1, 8'h00, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_LOAD,   1'b0, 8'hFF, 10'd1023}, 1'b0, NO_PIXELS},
    // literal of one byte at a frame start
    '{'{ACT_STREAM, 1'b1, 8'h81, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'h00, 10'd0},    1'b1, '{10'd0, 8'h00, 8'h00, PIX_ONE, 1'b1}},
    // repeat of zero count still eats its value byte
    '{'{ACT_STREAM, 1'b0, 8'h00, 10'd1023}, 1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'hFF, 10'd0},    1'b0, NO_PIXELS},
    // literal of zero count
    '{'{ACT_STREAM, 1'b0, 8'h80, 10'd0},    1'b0, NO_PIXELS},
    // odd repeat count
    '{'{ACT_STREAM, 1'b0, 8'h03, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'h01, 10'd0},    1'b0, NO_PIXELS},
    // longest repeat
    '{'{ACT_STREAM, 1'b0, 8'h7F, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'hFF, 10'd0},    1'b0, NO_PIXELS},
    // literal run with a load in the middle
    '{'{ACT_STREAM, 1'b0, 8'h82, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'hFF, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_LOAD,   1'b1, 8'hA5, 10'd512},  1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'h80, 10'd0},    1'b0, NO_PIXELS},
    // frame start cuts a literal run short
    '{'{ACT_STREAM, 1'b0, 8'h85, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'h10, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b1, 8'h02, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'h00, 10'd0},    1'b1, '{10'd0, 8'h00, 8'h01, PIX_TWO, 1'b1}},
    // single pixel repeat
    '{'{ACT_STREAM, 1'b0, 8'h01, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'h80, 10'd0},    1'b1, '{10'd2, 8'h82, 8'h00, PIX_ONE, 1'b1}},
    // frame start on a byte that would have been a literal
    '{'{ACT_STREAM, 1'b0, 8'h84, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b1, 8'h00, 10'd0},    1'b0, NO_PIXELS},
    '{'{ACT_STREAM, 1'b0, 8'h55, 10'd0},    1'b0, NO_PIXELS}
  };

  logic clk_i;
  logic rst_ni;

  rdfd_in_if  in_if ();
  rdfd_out_if out_if ();

  rle_delta_frame_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic [7:0]       base_shadow [FRAME_BYTES];
  logic [POS_W-1:0] pixel_pos;
  phase_e           parse_phase;
  logic [6:0]       run_left;
  rdfd_out_t        pending_pixels [$];

  int unsigned mismatches;
  int unsigned cycle_count;
  bit          send_calm;
  bit          take_calm;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // wait before the next request or result, with quiet stretches
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // decoded pixels for one accepted request
  task automatic decode_request(input rdfd_in_t req);
    logic [6:0] left;
    rdfd_out_t  pix;
    if (req.action == ACT_LOAD) begin
      base_shadow[req.base_addr] = req.data_byte;
      return;
    end
    if (req.frame_start) begin
      pixel_pos   = '0;
      parse_phase = PH_HEADER;
      run_left    = '0;
    end
    case (parse_phase)
      PH_LITERAL: begin
        pix             = '0;
        pix.pixel_addr  = pixel_pos;
        pix.pixel_first = base_shadow[pixel_pos] - req.data_byte;
        pix.pixel_count = PIX_ONE;
        pix.run_last    = 1'b1;
        pending_pixels.push_back(pix);
        pixel_pos = pixel_pos + 1'b1;
        run_left  = run_left - 1'b1;
        if (run_left == '0) parse_phase = PH_HEADER;
      end
      PH_VALUE: begin
        left = run_left;
        while (left != '0) begin
          pix             = '0;
          pix.pixel_addr  = pixel_pos;
          pix.pixel_first = base_shadow[pixel_pos] - req.data_byte;
          pixel_pos       = pixel_pos + 1'b1;
          if (left >= 7'd2) begin
            pix.pixel_second = base_shadow[pixel_pos] - req.data_byte;
            pix.pixel_count  = PIX_TWO;
            pixel_pos        = pixel_pos + 1'b1;
            left             = left - 7'd2;
          end else begin
            pix.pixel_count = PIX_ONE;
            left            = '0;
          end
          pix.run_last = (left == '0);
          pending_pixels.push_back(pix);
        end
        run_left    = '0;
        parse_phase = PH_HEADER;
      end
      default: begin
        run_left = req.data_byte[6:0] & COUNT_MASK;
        if (req.data_byte[MODE_BIT]) begin
          parse_phase = (run_left != '0) ? PH_LITERAL : PH_HEADER;
        end else begin
          parse_phase = PH_VALUE;
        end
      end
    endcase
  endtask

  // drive one request and record its pixels once it is taken
  task automatic send_request(input rdfd_in_t req, input logic typed, input rdfd_out_t want);
    int gap;
    int depth;
    bit taken;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (in_if.ready) begin
        depth = pending_pixels.size();
        decode_request(req);
        if (typed) begin
          while (pending_pixels.size() > depth) void'(pending_pixels.pop_back());
          pending_pixels.push_back(want);
        end
        taken = 1'b1;
      end
      @(posedge clk_i);
    end
  endtask

  function automatic rdfd_in_t make_req(logic action, logic fs, logic [7:0] byte_val);
    rdfd_in_t req;
    req.action      = action;
    req.frame_start = fs;
    req.data_byte   = byte_val;
    req.base_addr   = 10'($urandom_range(0, 1023));
    return req;
  endfunction

  // hold the sender until every predicted pixel has come out
  task automatic drain_pixels();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  // compare one result with the oldest predicted one
  task automatic check_pixels(input rdfd_out_t got);
    rdfd_out_t want;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result addr=%0d first=%02h second=%02h count=%0d last=%0b",
                 got.pixel_addr, got.pixel_first, got.pixel_second, got.pixel_count,
                 got.run_last);
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pixel_addr !== want.pixel_addr || got.pixel_first !== want.pixel_first ||
        got.pixel_second !== want.pixel_second || got.pixel_count !== want.pixel_count ||
        got.run_last !== want.run_last) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("pixel mismatch: exp addr=%0d first=%02h second=%02h count=%0d last=%0b, %s",
                 want.pixel_addr, want.pixel_first, want.pixel_second, want.pixel_count,
                 want.run_last,
                 $sformatf("got addr=%0d first=%02h second=%02h count=%0d last=%0b",
                           got.pixel_addr, got.pixel_first, got.pixel_second,
                           got.pixel_count, got.run_last));
    end
  endtask

  // result side: random stalls, check at the falling edge
  initial begin : result_side
    int stall;
    bit taken;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(take_calm);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk_i);
        if (out_if.valid === 1'b1) begin
          check_pixels(out_if.data);
          taken = 1'b1;
        end
        @(posedge clk_i);
      end
    end
  end

  // request side: preload, directed table, random streams
  initial begin : request_side
    int unsigned sent;
    int unsigned pick;
    int unsigned cnt;
    int unsigned nbytes;
    logic        restart;
    rdfd_in_t    req;

    rst_ni      <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    cycle_count = 0;
    mismatches  = 0;
    send_calm   = 1'b0;
    take_calm   = 1'b0;
    pixel_pos   = '0;
    parse_phase = PH_HEADER;
    run_left    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // low window of the base frame holds its own address, streams stay inside it
    for (int i = 0; i < PRELOAD_BYTES; i++) begin
      req           = make_req(ACT_LOAD, 1'($urandom_range(0, 1)), 8'(i));
      req.base_addr = 10'(i);
      send_request(req, 1'b0, NO_PIXELS);
    end

    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

    drain_pixels();

    // random streams: mostly well-formed runs, some loads, restarts and cut runs
    // a run restarts the frame when the parser is mid-run or it would leave the window
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick    = $urandom_range(0, 99);
      restart = (sent >= RESTART_FROM) && ($urandom_range(0, 19) == 0);
      if (pick < 5) begin
        send_request(make_req(ACT_LOAD, 1'($urandom_range(0, 1)), 8'($urandom)), 1'b0,
                     NO_PIXELS);
        sent++;
      end else if (pick < 8 && sent >= RESTART_FROM) begin
        send_request(make_req(ACT_STREAM, 1'b1, 8'($urandom)), 1'b0, NO_PIXELS);
        sent++;
      end else if (pick < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 10)      cnt = 0;
        else if (pick < 55) cnt = $urandom_range(1, 8);
        else                cnt = $urandom_range(9, 127);
        if (parse_phase != PH_HEADER || int'(pixel_pos) + cnt > PRELOAD_BYTES)
          restart = 1'b1;
        send_request(make_req(ACT_STREAM, restart, {1'b0, 7'(cnt)}), 1'b0, NO_PIXELS);
        send_request(make_req(ACT_STREAM, 1'b0, 8'($urandom)), 1'b0, NO_PIXELS);
        sent += 2;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5)       cnt = 0;
        else if (pick < 85) cnt = $urandom_range(1, 6);
        else                cnt = $urandom_range(7, 20);
        nbytes = cnt;
        if (cnt > 0 && $urandom_range(0, 9) == 0) nbytes = $urandom_range(0, cnt - 1);
        if (parse_phase != PH_HEADER || int'(pixel_pos) + cnt > PRELOAD_BYTES)
          restart = 1'b1;
        send_request(make_req(ACT_STREAM, restart, {1'b1, 7'(cnt)}), 1'b0, NO_PIXELS);
        for (int k = 0; k < nbytes; k++)
          send_request(make_req(ACT_STREAM, 1'b0, 8'($urandom)), 1'b0, NO_PIXELS);
        sent += nbytes + 1;
      end
    end

    drain_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
